@@ rtl/fbpst_pkg.sv @@
package fbpst_pkg;

    localparam int PAGES    = 64;
    localparam int PG_W     = $clog2(PAGES);
    localparam int CNT_W    = PG_W + 1;
    localparam int GRP      = 8;
    localparam int NGRP     = PAGES / GRP;
    localparam int GRP_W    = $clog2(GRP);
    localparam int CREDIT_W = 24;
    localparam int ADDR_W   = 2;

    localparam logic [CREDIT_W-1:0] ERASE_BUDGET_RST = 24'd100000;
    localparam logic [ADDR_W-1:0]   REG_ERASE_BUDGET = 2'd0;

    typedef enum logic [2:0] {
        OP_WRITE      = 3'd0,
        OP_INVALIDATE = 3'd1,
        OP_ERASE      = 3'd2,
        OP_FIND       = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        PG_EMPTY   = 2'd0,
        PG_VALID   = 2'd1,
        PG_INVALID = 2'd2
    } page_t;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_INACTIVE = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

endpackage

@@ rtl/flash_block_page_state_tracker_top.sv @@
// Page state tracker for one 64-page flash erase block. Each command beat on the
// s_ channel (write, invalidate, erase, find next empty page, query) yields one result
// beat on the m_ channel carrying the status and the block counts, mode and erase
// credit after the command. A command is taken in the idle state and executed in the
// execute state that follows, where the empty-page search resolves from a registered
// per-group summary of eight pages each; the execute state waits while an earlier
// result is still unread. erase_budget sits at byte address 0 of the APB port;
// writing it also reloads the remaining erase credit. Write only while idle.
module flash_block_page_state_tracker_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // page_index[5:0]
    input  logic [3:0]                        s_tuser,  // opcode[2:0], noop[3]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[0], block_status[2:1], valid_pages[9:3], invalid_pages[16:10],
    // erases_left[40:17], found_page[46:41], page_status[48:47]
    output logic [55:0]                       m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbpst_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import fbpst_pkg::*;

    dp_cmd_t             cmd;
    logic                cfg_we;
    logic [CREDIT_W-1:0] budget;
    logic                out_status;
    mode_t               out_mode;
    logic [CNT_W-1:0]    out_valid_cnt, out_inval_cnt;
    logic [CREDIT_W-1:0] out_credit;
    logic [PG_W-1:0]     out_found;
    page_t               out_pstat;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr == REG_ERASE_BUDGET);
    assign prdata = (paddr == REG_ERASE_BUDGET) ? {{(32-CREDIT_W){1'b0}}, budget} : '0;

    fbpst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    fbpst_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_opcode     (op_t'(s_tuser[2:0])),
        .in_page       (s_tdata[PG_W-1:0]),
        .in_noop       (s_tuser[3]),
        .cfg_we        (cfg_we),
        .cfg_data      (pwdata[CREDIT_W-1:0]),
        .budget        (budget),
        .out_status    (out_status),
        .out_mode      (out_mode),
        .out_valid_cnt (out_valid_cnt),
        .out_inval_cnt (out_inval_cnt),
        .out_credit    (out_credit),
        .out_found     (out_found),
        .out_pstat     (out_pstat)
    );

    assign m_tdata = {7'd0, out_pstat, out_found, out_credit, out_inval_cnt,
                      out_valid_cnt, out_mode, out_status};

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while another is executing");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[9:3]} + {1'b0, m_tdata[16:10]}) <= 8'(PAGES))
        else $error("valid plus invalid pages exceed block size");

    a_inactive_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] == MODE_INACTIVE) |-> m_tdata[16:10] == CNT_W'(PAGES))
        else $error("inactive block with pages not all invalid");

    a_free_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] == MODE_FREE) |-> m_tdata[16:3] == '0)
        else $error("free block reports used pages");

endmodule

@@ rtl/fbpst_ctrl.sv @@
module fbpst_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output fbpst_pkg::dp_cmd_t cmd
);
    import fbpst_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg & ~m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold while the previous result still sits unread
                if (!out_valid_reg || m_tready) begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/fbpst_dp.sv @@
module fbpst_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fbpst_pkg::dp_cmd_t                 cmd,
    input  fbpst_pkg::op_t                     in_opcode,
    input  logic [fbpst_pkg::PG_W-1:0]         in_page,
    input  logic                               in_noop,
    input  logic                               cfg_we,
    input  logic [fbpst_pkg::CREDIT_W-1:0]     cfg_data,
    output logic [fbpst_pkg::CREDIT_W-1:0]     budget,
    output logic                               out_status,
    output fbpst_pkg::mode_t                   out_mode,
    output logic [fbpst_pkg::CNT_W-1:0]        out_valid_cnt,
    output logic [fbpst_pkg::CNT_W-1:0]        out_inval_cnt,
    output logic [fbpst_pkg::CREDIT_W-1:0]     out_credit,
    output logic [fbpst_pkg::PG_W-1:0]         out_found,
    output fbpst_pkg::page_t                   out_pstat
);
    import fbpst_pkg::*;

    op_t               op_reg;
    logic [PG_W-1:0]   pg_reg;
    logic              noop_reg;

    logic [PAGES-1:0]    vbits_reg, vbits_next;
    logic [PAGES-1:0]    ibits_reg, ibits_next;
    logic [CNT_W-1:0]    vcnt_reg, vcnt_next;
    logic [CNT_W-1:0]    icnt_reg, icnt_next;
    mode_t               mode_reg, mode_next;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic [CREDIT_W-1:0] budget_reg;
    logic [PG_W-1:0]     start_reg, start_next;

    logic [NGRP-1:0]             grp_hit_reg, grp_hit_next;
    logic [NGRP-1:0][GRP_W-1:0]  grp_idx_reg, grp_idx_next;
    logic [PAGES-1:0]            empty_mask;

    logic            st_next;
    logic [PG_W-1:0] found_next;
    page_t           pstat_next;
    logic            find_hit;
    logic [PG_W-1:0] find_pg;
    logic            pg_valid, pg_inval;

    logic              status_reg;
    mode_t             omode_reg;
    logic [CNT_W-1:0]  ovcnt_reg, oicnt_reg;
    logic [CREDIT_W-1:0] ocredit_reg;
    logic [PG_W-1:0]   found_reg;
    page_t             pstat_reg;

    // first search stage: per-group hit and lowest empty page in the group
    always_comb begin
        empty_mask = ~(vbits_reg | ibits_reg) & ({PAGES{1'b1}} << start_reg);
        for (int g = 0; g < NGRP; g++) begin
            grp_hit_next[g] = |empty_mask[g*GRP +: GRP];
            grp_idx_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (empty_mask[g*GRP + b]) begin
                    grp_idx_next[g] = GRP_W'(b);
                end
            end
        end
    end

    // second search stage: first group with a hit
    always_comb begin
        find_hit = 1'b0;
        find_pg  = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_hit_reg[g]) begin
                find_hit = 1'b1;
                find_pg  = PG_W'(g * GRP + int'(grp_idx_reg[g]));
            end
        end
    end

    assign pg_valid = vbits_reg[pg_reg];
    assign pg_inval = ibits_reg[pg_reg];

    always_comb begin
        vbits_next  = vbits_reg;
        ibits_next  = ibits_reg;
        vcnt_next   = vcnt_reg;
        icnt_next   = icnt_reg;
        mode_next   = mode_reg;
        credit_next = credit_reg;
        start_next  = start_reg;
        st_next     = 1'b0;
        found_next  = '0;
        pstat_next  = PG_EMPTY;
        unique case (op_reg)
            OP_WRITE: begin
                if (!noop_reg) begin
                    if (pg_valid || pg_inval) begin
                        st_next = 1'b1;
                    end else begin
                        vbits_next[pg_reg] = 1'b1;
                        vcnt_next          = vcnt_reg + 1'b1;
                        mode_next          = MODE_ACTIVE;
                    end
                end
            end
            OP_INVALIDATE: begin
                if (!pg_inval) begin
                    if (pg_valid) begin
                        vbits_next[pg_reg] = 1'b0;
                        vcnt_next          = vcnt_reg - 1'b1;
                    end
                    ibits_next[pg_reg] = 1'b1;
                    icnt_next          = icnt_reg + 1'b1;
                    mode_next = (icnt_next >= CNT_W'(PAGES)) ? MODE_INACTIVE : MODE_ACTIVE;
                end
            end
            OP_ERASE: begin
                if (!noop_reg) begin
                    if (credit_reg == '0) begin
                        st_next = 1'b1;
                    end else begin
                        vbits_next  = '0;
                        ibits_next  = '0;
                        vcnt_next   = '0;
                        icnt_next   = '0;
                        mode_next   = MODE_FREE;
                        start_next  = '0;
                        credit_next = credit_reg - 1'b1;
                    end
                end
            end
            OP_FIND: begin
                if (find_hit) begin
                    start_next = find_pg;
                    found_next = find_pg;
                end else begin
                    st_next = 1'b1;
                end
            end
            OP_QUERY: begin
                if (pg_inval) begin
                    pstat_next = PG_INVALID;
                end else if (pg_valid) begin
                    pstat_next = PG_VALID;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg   <= '0;
            ibits_reg   <= '0;
            vcnt_reg    <= '0;
            icnt_reg    <= '0;
            mode_reg    <= MODE_FREE;
            credit_reg  <= ERASE_BUDGET_RST;
            budget_reg  <= ERASE_BUDGET_RST;
            start_reg   <= '0;
            grp_hit_reg <= '0;
        end else begin
            grp_hit_reg <= grp_hit_next;
            if (cfg_we) begin
                budget_reg <= cfg_data;
                credit_reg <= cfg_data;
            end else if (cmd.commit) begin
                credit_reg <= credit_next;
            end
            if (cmd.commit) begin
                vbits_reg <= vbits_next;
                ibits_reg <= ibits_next;
                vcnt_reg  <= vcnt_next;
                icnt_reg  <= icnt_next;
                mode_reg  <= mode_next;
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_idx_reg <= grp_idx_next;
        if (cmd.load) begin
            op_reg   <= in_opcode;
            pg_reg   <= in_page;
            noop_reg <= in_noop;
        end
        if (cmd.commit) begin
            status_reg  <= st_next;
            omode_reg   <= mode_next;
            ovcnt_reg   <= vcnt_next;
            oicnt_reg   <= icnt_next;
            ocredit_reg <= credit_next;
            found_reg   <= found_next;
            pstat_reg   <= pstat_next;
        end
    end

    assign budget        = budget_reg;
    assign out_status    = status_reg;
    assign out_mode      = omode_reg;
    assign out_valid_cnt = ovcnt_reg;
    assign out_inval_cnt = oicnt_reg;
    assign out_credit    = ocredit_reg;
    assign out_found     = found_reg;
    assign out_pstat     = pstat_reg;

endmodule
